// ----- hw/rtl/sdf_pkg.sv -----
// Shared types and constants for the signed decimal field formatter.
package sdf_pkg;

   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 8;
   localparam int POS_W      = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FIELD_WIDTH     = 3'd0;
   localparam logic [2:0] REG_PRECISION       = 3'd1;
   localparam logic [2:0] REG_PRECISION_GIVEN = 3'd2;
   localparam logic [2:0] REG_ZERO_PAD        = 3'd3;
   localparam logic [2:0] REG_PLUS_FLAG       = 3'd4;
   localparam logic [2:0] REG_SPACE_FLAG      = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // converter status toward the sequencer
   typedef struct packed {
      logic done;      // one-cycle pulse, digits valid
      logic overflow;  // magnitude had more digits than kept
      logic is_zero;   // magnitude was zero
   } conv_stat_type;

endpackage

// ----- hw/rtl/sdf_channels.sv -----
// Valid/ready channel interfaces for input values and output characters.
interface sdf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sdf_pkg::VALUE_W-1:0]  value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sdf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sdf_pkg::CHAR_W-1:0]   character;
   logic [sdf_pkg::POS_W-1:0]    position;
   logic                         last;
   modport source (output valid, output character, output position, output last, input ready);
   modport sink   (input valid, input character, input position, input last, output ready);
endinterface

// ----- hw/rtl/sdf_bin2bcd.sv -----
// Bit-serial binary to BCD converter (shift and add 3), low digits kept.
module sdf_bin2bcd #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VALUE_BITS-1:0]       mag,
   output logic [MAX_DIGITS*4-1:0]     bcd,
   output sdf_pkg::conv_stat_type      stat
);

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int BCD_W = MAX_DIGITS * 4;

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  ovf_ff, ovf_in;
   logic                  nz_ff, nz_in;
   logic [BCD_W-1:0]      adj;

   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                   : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      ovf_in   = ovf_ff;
      nz_in    = nz_ff;
      if (start) begin
         shift_in = mag;
         bcd_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
         ovf_in   = 1'b0;
         nz_in    = 1'b0;
      end else if (busy_ff) begin
         bcd_in   = {adj[BCD_W-2:0], shift_ff[VALUE_BITS-1]};
         ovf_in   = ovf_ff | adj[BCD_W-1];
         nz_in    = nz_ff | shift_ff[VALUE_BITS-1];
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      ovf_ff   <= ovf_in;
      nz_ff    <= nz_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign bcd           = bcd_ff;
   assign stat.done     = done_ff;
   assign stat.overflow = ovf_ff;
   assign stat.is_zero  = ~nz_ff;

endmodule

// ----- hw/rtl/signed_decimal_field_formatter.sv -----
// Top level: printf %d style formatter, one ASCII character per output item.
//
//  channel  dir  handshake        payload
//  req_if   in   valid/ready      value (64b signed)
//  rsp_if   out  valid/ready      character (8b), position (6b), last
//  csr_*    in   APB write/read   field_width, precision, precision_given,
//                                 zero_pad, plus_flag, space_flag
//
// Steps per item: acceptance, bit-serial BCD conversion, a leading-zero scan,
// sizing (ST_SIZE, then ST_BOUND), then emission of one character per cycle
// while the output is not stalled (0 to MAX_FIELD+1 characters).
// One value is in work at a time; req_if.ready is high only when idle.
// The output register stalls the emitter while rsp_if.ready is low.
// Reset (synchronous, active high) clears control state and the CSR registers.
module signed_decimal_field_formatter #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 19,
   parameter int MAX_FIELD  = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   sdf_req_if.sink                             req_if,
   sdf_rsp_if.source                           rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sdf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sdf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int BCD_W = MAX_DIGITS * 4;
   localparam int LZ_W  = $clog2(MAX_DIGITS);
   localparam int ND_W  = $clog2(MAX_DIGITS + 1);
   localparam int CW    = 7;                  // run counts up to 64
   localparam int LIMIT = MAX_FIELD + 1;      // longest run

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SIZE  = 3'd3;
   localparam logic [2:0] ST_BOUND = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   // ---------------------------------------------------------------- CSRs
   logic [5:0] field_width_ff, precision_ff;
   logic       precision_given_ff, zero_pad_ff, plus_flag_ff, space_flag_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff     <= '0;
         precision_ff       <= '0;
         precision_given_ff <= 1'b0;
         zero_pad_ff        <= 1'b0;
         plus_flag_ff       <= 1'b0;
         space_flag_ff      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            sdf_pkg::REG_FIELD_WIDTH:     field_width_ff     <= csr_pwdata[5:0];
            sdf_pkg::REG_PRECISION:       precision_ff       <= csr_pwdata[5:0];
            sdf_pkg::REG_PRECISION_GIVEN: precision_given_ff <= csr_pwdata[0];
            sdf_pkg::REG_ZERO_PAD:        zero_pad_ff        <= csr_pwdata[0];
            sdf_pkg::REG_PLUS_FLAG:       plus_flag_ff       <= csr_pwdata[0];
            sdf_pkg::REG_SPACE_FLAG:      space_flag_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         sdf_pkg::REG_FIELD_WIDTH:     csr_prdata[5:0] = field_width_ff;
         sdf_pkg::REG_PRECISION:       csr_prdata[5:0] = precision_ff;
         sdf_pkg::REG_PRECISION_GIVEN: csr_prdata[0]   = precision_given_ff;
         sdf_pkg::REG_ZERO_PAD:        csr_prdata[0]   = zero_pad_ff;
         sdf_pkg::REG_PLUS_FLAG:       csr_prdata[0]   = plus_flag_ff;
         sdf_pkg::REG_SPACE_FLAG:      csr_prdata[0]   = space_flag_ff;
         default:                      csr_prdata      = '0;
      endcase
   end

   // saturated width and precision
   logic [5:0] width_sat, prec_sat;
   logic       zfill;
   assign width_sat = (field_width_ff > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : field_width_ff;
   assign prec_sat  = (precision_ff > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : precision_ff;
   assign zfill     = zero_pad_ff & ~precision_given_ff;

   // ---------------------------------------------------------- conversion
   logic [2:0]            state_ff, state_in;
   logic                  accept;
   logic [VALUE_BITS-1:0] raw, mag;
   logic [BCD_W-1:0]      conv_bcd;
   sdf_pkg::conv_stat_type conv_stat;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid & req_if.ready;
   assign raw          = req_if.value[VALUE_BITS-1:0];
   // most negative value wraps to its unsigned magnitude
   assign mag          = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

   sdf_bin2bcd #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_bin2bcd (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .mag   (mag),
      .bcd   (conv_bcd),
      .stat  (conv_stat)
   );

   // ------------------------------------------------------------ sequencer
   logic                  neg_ff, neg_in;
   logic                  ovf_ff, ovf_in;
   logic                  zero_ff, zero_in;
   logic [BCD_W-1:0]      digits_ff, digits_in;
   logic [LZ_W-1:0]       lz_ff, lz_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [5:0]            ndig_ff, ndig_in;
   logic                  has_sign_ff, has_sign_in;
   logic [7:0]            sign_char_ff, sign_char_in;
   logic [CW-1:0]         b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [CW-1:0]         len_ff, len_in, pos_ff, pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic [5:0]            rsp_pos_ff, rsp_pos_in;
   logic                  rsp_last_ff, rsp_last_in;

   // sizing helpers
   logic [ND_W-1:0] nd_calc;
   logic [CW-1:0]   sized, pad, lead, zcount, b2_calc, b3_calc, total;
   logic            advance, is_last;
   logic [3:0]      top_digit;

   assign top_digit = digits_ff[BCD_W-1 -: 4];
   assign advance   = ~rsp_valid_ff | rsp_if.ready;
   assign is_last   = (pos_ff == len_ff - 1'b1);

   always_comb begin
      // digits kept: none for explicit zero precision on zero, else those after leading zeros
      if (precision_given_ff && (precision_ff == 6'd0) && zero_ff)
         nd_calc = '0;
      else
         nd_calc = ND_W'(MAX_DIGITS) - ND_W'(lz_ff);
      sized   = CW'(ndig_ff) + CW'(has_sign_ff);
      pad     = (CW'(width_sat) > sized) ? (CW'(width_sat) - sized) : '0;
      lead    = zfill ? '0 : pad;
      zcount  = (zfill ? pad : '0) + CW'(ndig_ff) - CW'(nd_ff);
      b2_calc = lead + CW'(has_sign_ff);
      b3_calc = b2_calc + zcount;
      total   = b3_calc + CW'(nd_ff);
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      zero_in      = zero_ff;
      digits_in    = digits_ff;
      lz_in        = lz_ff;
      nd_in        = nd_ff;
      ndig_in      = ndig_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = raw[VALUE_BITS-1];
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               digits_in = conv_bcd;
               ovf_in    = conv_stat.overflow;
               zero_in   = conv_stat.is_zero;
               lz_in     = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zero digits one per cycle; the last digit always stays
            if (!ovf_ff && (lz_ff != LZ_W'(MAX_DIGITS - 1)) && (top_digit == 4'd0)) begin
               digits_in = {digits_ff[BCD_W-5:0], 4'd0};
               lz_in     = lz_ff + 1'b1;
            end else begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            nd_in   = nd_calc;
            ndig_in = (prec_sat > 6'(nd_calc)) ? prec_sat : 6'(nd_calc);
            if (neg_ff) begin
               has_sign_in  = 1'b1;
               sign_char_in = sdf_pkg::CHAR_MINUS;
            end else if (plus_flag_ff) begin
               has_sign_in  = 1'b1;
               sign_char_in = sdf_pkg::CHAR_PLUS;
            end else if (space_flag_ff) begin
               has_sign_in  = 1'b1;
               sign_char_in = sdf_pkg::CHAR_SPACE;
            end else begin
               has_sign_in  = 1'b0;
               sign_char_in = sdf_pkg::CHAR_SPACE;
            end
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            b1_in    = lead;
            b2_in    = b2_calc;
            b3_in    = b3_calc;
            len_in   = (total > CW'(LIMIT)) ? CW'(LIMIT) : total;
            pos_in   = '0;
            state_in = (total == '0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff[5:0];
               rsp_last_in  = is_last;
               if (pos_ff < b1_ff) begin
                  rsp_char_in = sdf_pkg::CHAR_SPACE;
               end else if (pos_ff < b2_ff) begin
                  rsp_char_in = sign_char_ff;
               end else if (pos_ff < b3_ff) begin
                  rsp_char_in = sdf_pkg::CHAR_ZERO;
               end else begin
                  rsp_char_in = sdf_pkg::CHAR_ZERO + {4'd0, top_digit};
                  digits_in   = {digits_ff[BCD_W-5:0], 4'd0};
               end
               pos_in = pos_ff + 1'b1;
               if (is_last)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      ovf_ff       <= ovf_in;
      zero_ff      <= zero_in;
      digits_ff    <= digits_in;
      lz_ff        <= lz_in;
      nd_ff        <= nd_in;
      ndig_ff      <= ndig_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      b3_ff        <= b3_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.character = rsp_char_ff;
   assign rsp_if.position  = rsp_pos_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for signed_decimal_field_formatter: directed and random values.
module tb_top;

   // Must match the defaults of the block under test.
   localparam int MAX_DIGITS = 19;
   localparam int MAX_FIELD  = 63;
   // A run never exceeds 64 characters, or MAX_FIELD+1 if that is smaller.
   localparam int MAX_RUN    = (MAX_FIELD + 1 > 64) ? 64 : MAX_FIELD + 1;
   localparam int NUM_REGS   = 6;

   // Quiet time after the last character before the registers change. An item
   // that formats to nothing gives no character, yet the block is still busy
   // on it: conversion, digit scan and sizing.
   localparam int SETTLE_CYCLES = 200;
   // Cycles with no accepted item, character or register write before we give up.
   localparam int QUIET_LIMIT   = 5000;
   localparam int ITEMS_PER_PHASE   = 115;
   localparam int ITEMS_PER_FORMAT  = 23;

   // Format registers as the block sees them.
   typedef struct packed {
      logic [5:0] width;
      logic [5:0] prec;
      logic       prec_given;
      logic       zero_pad;
      logic       plus;
      logic       space;
   } fmt_cfg_type;

   // One character of the formatted run.
   typedef struct packed {
      logic [sdf_pkg::CHAR_W-1:0] character;
      logic [sdf_pkg::POS_W-1:0]  position;
      logic                       last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [sdf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [sdf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [sdf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sdf_req_if req_ch();
   sdf_rsp_if rsp_ch();

   // Shadow of the format registers; reset values are all zero.
   fmt_cfg_type   fmt_cfg = '0;
   // Characters predicted but not yet seen on the output, oldest first.
   text_char_type pending_text[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int req_idle_pct   = 0;  // chance per cycle that the sender holds off
   int rsp_stall_pct  = 0;  // chance per cycle that the receiver stalls

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   signed_decimal_field_formatter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------
   // Predictor: builds the printf %d text of one value under the current
   // format and queues its characters.
   //   layout without zero fill: [spaces][sign][leading zeros][digits]
   //   layout with zero fill:    [sign][zeros][leading zeros][digits]
   // Zero fill applies only when zero_pad is set and no precision is given.
   // ------------------------------------------------------------------
   function automatic void predict_text(input logic [sdf_pkg::VALUE_W-1:0] raw);
      logic [sdf_pkg::VALUE_W-1:0] magnitude;
      logic [3:0]                  digits [MAX_DIGITS];
      logic [sdf_pkg::CHAR_W-1:0]  sign_ch;
      logic [sdf_pkg::CHAR_W-1:0]  run [$];
      logic                        zfill;
      int                          has_sign;
      int                          nd;
      int                          ndig;
      int                          pad;
      int                          n;
      int                          i;
      text_char_type               c;
      // Two's complement negate; the most negative value maps onto 2^63.
      magnitude = raw[sdf_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
      nd = 0;
      // Zero with an explicit precision of 0 prints no digits at all.
      if (!(fmt_cfg.prec_given && fmt_cfg.prec == 0 && magnitude == 0)) begin
         do begin
            digits[nd] = 4'(magnitude % 10);
            magnitude  = magnitude / 10;
            nd++;
         end while (magnitude != 0 && nd < MAX_DIGITS);
      end
      ndig = (int'(fmt_cfg.prec) > nd) ? int'(fmt_cfg.prec) : nd;
      // Minus, then plus (wins over space), then space.
      has_sign = 1;
      if (raw[sdf_pkg::VALUE_W-1])
         sign_ch = sdf_pkg::CHAR_MINUS;
      else if (fmt_cfg.plus)
         sign_ch = sdf_pkg::CHAR_PLUS;
      else if (fmt_cfg.space)
         sign_ch = sdf_pkg::CHAR_SPACE;
      else begin
         sign_ch  = sdf_pkg::CHAR_SPACE;
         has_sign = 0;
      end
      pad = int'(fmt_cfg.width) - ndig - has_sign;
      if (pad < 0)
         pad = 0;
      zfill = fmt_cfg.zero_pad && !fmt_cfg.prec_given;
      if (!zfill)
         repeat (pad) run.push_back(sdf_pkg::CHAR_SPACE);
      if (has_sign != 0)
         run.push_back(sign_ch);
      if (zfill)
         repeat (pad) run.push_back(sdf_pkg::CHAR_ZERO);
      repeat (ndig - nd) run.push_back(sdf_pkg::CHAR_ZERO);
      for (i = nd - 1; i >= 0; i--)
         run.push_back(sdf_pkg::CHAR_ZERO + sdf_pkg::CHAR_W'(digits[i]));
      // Overlong runs are cut; the last kept character carries the end mark.
      n = (run.size() > MAX_RUN) ? MAX_RUN : run.size();
      for (i = 0; i < n; i++) begin
         c.character = run[i];
         c.position  = sdf_pkg::POS_W'(i);
         c.last      = (i == n - 1);
         pending_text.push_back(c);
      end
   endfunction

   function automatic void report_mismatch(input string field, input logic [31:0] want,
                                           input logic [31:0] got);
      mismatch_count++;
      $error("%s: expected %0h, got %0h", field, want, got);
   endfunction

   // ------------------------------------------------------------------
   // Monitors. All sample at the rising edge, so they see the values that
   // the edge itself saw.
   // ------------------------------------------------------------------

   // Every accepted value is predicted with the format in force right then.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         predict_text(req_ch.value);
   end

   // Each character is compared with the oldest predicted one.
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_text.size() == 0) begin
            report_mismatch("unexpected character", '0, 32'(rsp_ch.character));
         end else begin
            want = pending_text.pop_front();
            if (rsp_ch.character !== want.character)
               report_mismatch("character", 32'(want.character), 32'(rsp_ch.character));
            if (rsp_ch.position !== want.position)
               report_mismatch("position", 32'(want.position), 32'(rsp_ch.position));
            if (rsp_ch.last !== want.last)
               report_mismatch("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   // Receiver: stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ch.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: any handshake of any port counts as progress.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offers one value and returns at the edge that accepts it. valid stays
   // high afterward so back-to-back values need no second assignment in the
   // same step; wait_idle or the next hold-off lowers it.
   task automatic send_value(input logic [sdf_pkg::VALUE_W-1:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // APB write: setup, then access until pready. psel stays high so writes
   // can run back to back; the caller drops it.
   task automatic csr_write(input logic [2:0] index,
                            input logic [sdf_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // Registers keep only their low bits; other indexes are ignored.
      case (index)
         sdf_pkg::REG_FIELD_WIDTH:     fmt_cfg.width      = data[5:0];
         sdf_pkg::REG_PRECISION:       fmt_cfg.prec       = data[5:0];
         sdf_pkg::REG_PRECISION_GIVEN: fmt_cfg.prec_given = data[0];
         sdf_pkg::REG_ZERO_PAD:        fmt_cfg.zero_pad   = data[0];
         sdf_pkg::REG_PLUS_FLAG:       fmt_cfg.plus       = data[0];
         sdf_pkg::REG_SPACE_FLAG:      fmt_cfg.space      = data[0];
         default: ;
      endcase
   endtask

   // Random junk above the register's own bits, to check the masking.
   function automatic logic [sdf_pkg::CSR_DATA_W-1:0] noisy(input int bits,
                                                             input logic [5:0] v);
      return ($urandom() << bits) | sdf_pkg::CSR_DATA_W'(v);
   endfunction

   // Stop offering values, wait one edge so the last accepted value is
   // predicted, let every predicted character arrive, then let the block
   // finish any value that formats to nothing.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_text.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprograms the whole format, plus one write outside the register map.
   task automatic apply_format(input fmt_cfg_type c);
      wait_idle();
      csr_write(sdf_pkg::REG_FIELD_WIDTH, noisy(6, c.width));
      csr_write(sdf_pkg::REG_PRECISION, noisy(6, c.prec));
      csr_write(sdf_pkg::REG_PRECISION_GIVEN, noisy(1, 6'(c.prec_given)));
      csr_write(sdf_pkg::REG_ZERO_PAD, noisy(1, 6'(c.zero_pad)));
      csr_write(sdf_pkg::REG_PLUS_FLAG, noisy(1, 6'(c.plus)));
      csr_write(sdf_pkg::REG_SPACE_FLAG, noisy(1, 6'(c.space)));
      csr_write(3'(NUM_REGS + $urandom_range(1)), $urandom());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic fmt_cfg_type make_format(input int width, input int prec,
                                               input bit prec_given, input bit zero_pad,
                                               input bit plus, input bit space);
      fmt_cfg_type c;
      c.width      = 6'(width);
      c.prec       = 6'(prec);
      c.prec_given = prec_given;
      c.zero_pad   = zero_pad;
      c.plus       = plus;
      c.space      = space;
      return c;
   endfunction

   // Mostly short fields so runs stay short; sometimes the full range.
   function automatic logic [5:0] random_size();
      case ($urandom_range(9))
         0:       return 6'd0;
         1:       return 6'(MAX_FIELD);
         2, 3:    return 6'($urandom_range(MAX_FIELD));
         default: return 6'($urandom_range(12));
      endcase
   endfunction

   function automatic fmt_cfg_type random_format();
      return make_format(int'(random_size()), int'(random_size()),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   // Full-range values, short values, powers of ten and their neighbors
   // (digit count boundaries), and the extremes, each with either sign.
   function automatic logic [sdf_pkg::VALUE_W-1:0] random_value();
      logic [sdf_pkg::VALUE_W-1:0] v;
      int                          k;
      case ($urandom_range(7))
         0:       v = {$urandom(), $urandom()} >> $urandom_range(sdf_pkg::VALUE_W - 1);
         1:       v = sdf_pkg::VALUE_W'($urandom_range(999));
         2: begin
            v = 64'd1;
            for (k = $urandom_range(MAX_DIGITS - 1); k > 0; k--)
               v = v * 10;
            v = v - sdf_pkg::VALUE_W'($urandom_range(1));
         end
         3:       v = $urandom_range(1) ? {1'b0, {(sdf_pkg::VALUE_W-1){1'b1}}} : '0;
         default: v = {$urandom(), $urandom()};
      endcase
      if ($urandom_range(1))
         v = -v;
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Formats under the reset values of the registers (no write yet).
   task automatic test_reset_format();
      send_value(64'sd0);
      send_value(64'sd7);
      send_value(-64'sd42);
   endtask

   task automatic test_directed();
      // Zero with explicit precision 0 and no sign or width: no characters.
      apply_format(make_format(0, 0, 1, 0, 0, 0));
      send_value(64'sd0);
      send_value(64'sd5);
      // Empty digits but a sign and space pad remain.
      apply_format(make_format(6, 0, 1, 0, 1, 0));
      send_value(64'sd0);
      send_value(-64'sd1);
      // Zero pad is ignored when precision is given.
      apply_format(make_format(12, 3, 1, 1, 0, 1));
      send_value(64'sd7);
      // Plus beats space; zero fill goes after the sign.
      apply_format(make_format(25, 0, 0, 1, 1, 1));
      send_value({1'b0, {(sdf_pkg::VALUE_W-1){1'b1}}});
      send_value(64'sd42);
      send_value({1'b1, {(sdf_pkg::VALUE_W-1){1'b0}}});
      // Widest field and precision: runs of the full 64 characters.
      apply_format(make_format(MAX_FIELD, MAX_FIELD, 1, 1, 1, 0));
      send_value(-64'sd1);
      send_value({1'b0, {(sdf_pkg::VALUE_W-1){1'b1}}});
      // Most negative value, and zero, under a wide space pad.
      apply_format(make_format(MAX_FIELD, 0, 0, 0, 0, 0));
      send_value({1'b1, {(sdf_pkg::VALUE_W-1){1'b0}}});
      send_value(64'sd0);
      // Space flag alone, with precision 20 given.
      apply_format(make_format(0, 20, 1, 0, 0, 1));
      send_value(64'sd123);
      send_value({1'b1, {(sdf_pkg::VALUE_W-1){1'b0}}});
   endtask

   // Random values under a string of random formats with the given idling and stalling.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int i;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (i % ITEMS_PER_FORMAT == 0)
            apply_format(random_format());
         send_value(random_value());
      end
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.value  = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_format();
      test_directed();
      test_random_traffic(0, 0);
      test_random_traffic(77, 0);
      test_random_traffic(0, 77);
      test_random_traffic(20, 20);

      wait_idle();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
